// ===== hdl/ahs_pkg.sv =====
package ahs_pkg;

  // Command codes carried in tuser
  typedef enum logic [1:0] {
    CMD_WRITE_SLOT = 2'd0,
    CMD_CLEAR_SLOT = 2'd1,
    CMD_WRITE_TYPE = 2'd2,
    CMD_QUERY      = 2'd3
  } cmd_t;

  localparam int POS_W   = 16;
  localparam int COORD_W = 18;   // exact bound arithmetic, no wrap
  localparam int SLOT_W  = 5;
  localparam int TYPE_W  = 8;
  localparam int HIT_W   = 4;
  localparam int IDX_W   = 9;    // holds any slot index up to 256

  typedef logic signed [POS_W-1:0]   pos_t;
  typedef logic [POS_W-1:0]          dim_t;
  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x_lo;
    coord_t x_hi;
    coord_t y_lo;
    coord_t y_hi;
    coord_t z_lo;
    coord_t z_hi;
  } box_t;

  // Query token passed from cell to cell
  typedef struct packed {
    logic              valid;
    logic              found;
    logic [HIT_W-1:0]  hit_slot;
    logic [SLOT_W-1:0] start;
    logic [SLOT_W-1:0] ignore;
    box_t              q;
  } token_t;

  // Table update broadcast to every cell
  typedef struct packed {
    logic              ent_we;
    logic              dims_we;
    logic              clr;
    logic [SLOT_W-1:0] slot;
    logic [TYPE_W-1:0] etype;
    pos_t              px;
    pos_t              py;
    pos_t              pz;
    dim_t              rad;
    dim_t              hgt;
  } upd_t;

  function automatic coord_t sext(input pos_t v);
    sext = {{(COORD_W - POS_W){v[POS_W-1]}}, v};
  endfunction

  function automatic box_t entity_box(input pos_t px, input pos_t py, input pos_t pz,
                                      input dim_t rad, input dim_t hgt);
    coord_t hr;
    coord_t hh;
    dim_t   ywrap;
    box_t   b;
    hr    = {{(COORD_W - POS_W + 1){1'b0}}, rad[POS_W-1:1]};
    hh    = {{(COORD_W - POS_W + 1){1'b0}}, hgt[POS_W-1:1]};
    ywrap = dim_t'(py) - {1'b0, hgt[POS_W-1:1]};
    b.x_lo = sext(px) - hr;
    b.x_hi = sext(px) + hr;
    b.y_lo = sext(pos_t'(ywrap)) - hh;
    b.y_hi = sext(pos_t'(ywrap)) + hh;
    b.z_lo = sext(pz) - hr;
    b.z_hi = sext(pz) + hr;
    return b;
  endfunction

  function automatic box_t query_box(input pos_t px, input pos_t py, input pos_t pz,
                                     input pos_t ex, input pos_t ey, input pos_t ez);
    box_t b;
    b.x_lo = sext(px) - sext(ex);
    b.x_hi = sext(px) + sext(ex);
    b.y_lo = sext(py) - sext(ey);
    b.y_hi = sext(py) + sext(ey);
    b.z_lo = sext(pz) - sext(ez);
    b.z_hi = sext(pz) + sext(ez);
    return b;
  endfunction

  // Touching counts as overlap
  function automatic logic boxes_overlap(input box_t e, input box_t q);
    logic apart;
    apart = (e.x_hi < q.x_lo) || (e.x_lo > q.x_hi) ||
            (e.y_hi < q.y_lo) || (e.y_lo > q.y_hi) ||
            (e.z_hi < q.z_lo) || (e.z_lo > q.z_hi);
    return !apart;
  endfunction

endpackage

// ===== hdl/aabb_entity_hit_search.sv =====
// Query: the token is registered at entry, passes every cell and the result lands in the
//   output register; the token walks the slot chain one cell per cycle. Next transaction
//   accepted once the token has left the last cell, later while two results wait unread.
// Slot write: type table read, then cell load. Clear and type write act as accepted.
// Reset (rst, synchronous, active high) empties all slots and the result queue;
// type dimensions and slot contents stay undefined until written.
module aabb_entity_hit_search import ahs_pkg::*; #(
  parameter int ENTITY_SLOTS = 16,
  parameter int TYPE_COUNT   = 256
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // slot[4:0], ignore_slot[9:5], entity_type[17:10], pos_x[33:18], pos_y[49:34],
  // pos_z[65:50], ext_x[81:66], ext_y[97:82], ext_z[113:98], type_radius[129:114],
  // type_height[145:130], zero fill[151:146]
  input  logic [151:0] s_axis_tdata,
  // command[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // hit_found[0], hit_slot[4:1], zero fill[7:5]
  output logic [7:0]   m_axis_tdata
);

  localparam int TYPE_AW = (TYPE_COUNT > 1) ? $clog2(TYPE_COUNT) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ENT_WR,
    ST_QUERY
  } state_t;

  state_t state;

  // Unpack the input transaction
  cmd_t              in_cmd;
  logic [SLOT_W-1:0] in_slot;
  logic [SLOT_W-1:0] in_ignore;
  logic [TYPE_W-1:0] in_type;
  pos_t              in_px, in_py, in_pz;
  pos_t              in_ex, in_ey, in_ez;
  dim_t              in_rad, in_hgt;
  logic              in_type_ok;
  logic              accept;

  assign in_cmd    = cmd_t'(s_axis_tuser);
  assign in_slot   = s_axis_tdata[4:0];
  assign in_ignore = s_axis_tdata[9:5];
  assign in_type   = s_axis_tdata[17:10];
  assign in_px     = s_axis_tdata[33:18];
  assign in_py     = s_axis_tdata[49:34];
  assign in_pz     = s_axis_tdata[65:50];
  assign in_ex     = s_axis_tdata[81:66];
  assign in_ey     = s_axis_tdata[97:82];
  assign in_ez     = s_axis_tdata[113:98];
  assign in_rad    = s_axis_tdata[129:114];
  assign in_hgt    = s_axis_tdata[145:130];

  // Types beyond the table read as zero size and are never written
  assign in_type_ok = ({1'b0, in_type} < 9'(TYPE_COUNT));

  logic pend_valid;
  assign s_axis_tready = (state == ST_IDLE) && !pend_valid;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Type dimension table: {height, radius}
  logic                ram_we;
  logic [2*POS_W-1:0]  rd_data;

  assign ram_we = accept && (in_cmd == CMD_WRITE_TYPE) && in_type_ok;

  ahs_ram #(
    .WIDTH (2 * POS_W),
    .DEPTH (TYPE_COUNT)
  ) u_type_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_type[TYPE_AW-1:0]),
    .wdata ({in_hgt, in_rad}),
    .raddr (in_type[TYPE_AW-1:0]),
    .rdata (rd_data)
  );

  // Slot write held while the type table is read
  logic [SLOT_W-1:0] wr_slot;
  logic [TYPE_W-1:0] wr_type;
  logic              wr_type_ok;
  pos_t              wr_px, wr_py, wr_pz;

  // Broadcast updates to the cells. Slot loads and type writes never share a cycle.
  upd_t upd;
  always_comb begin
    upd.ent_we  = (state == ST_ENT_WR);
    upd.dims_we = ram_we;
    upd.clr     = accept && (in_cmd == CMD_CLEAR_SLOT);
    upd.slot    = upd.ent_we ? wr_slot : in_slot;
    upd.etype   = upd.ent_we ? wr_type : in_type;
    upd.px      = wr_px;
    upd.py      = wr_py;
    upd.pz      = wr_pz;
    if (upd.ent_we) begin
      upd.rad = wr_type_ok ? rd_data[POS_W-1:0]       : '0;
      upd.hgt = wr_type_ok ? rd_data[2*POS_W-1:POS_W] : '0;
    end else begin
      upd.rad = in_rad;
      upd.hgt = in_hgt;
    end
  end

  // Slot chain: cell i tests slot i against the passing query token
  token_t tok_entry;
  token_t chain [ENTITY_SLOTS];

  for (genvar i = 0; i < ENTITY_SLOTS; i++) begin : g_cell
    if (i == 0) begin : g_first
      ahs_cell #(.INDEX(i)) u_cell (
        .clk     (clk),
        .rst     (rst),
        .upd     (upd),
        .tok_in  (tok_entry),
        .tok_out (chain[i])
      );
    end else begin : g_next
      ahs_cell #(.INDEX(i)) u_cell (
        .clk     (clk),
        .rst     (rst),
        .upd     (upd),
        .tok_in  (chain[i-1]),
        .tok_out (chain[i])
      );
    end
  end

  // Two-deep result queue: output register plus one spare
  token_t     res;
  logic       push;
  logic       pop;
  logic [7:0] res_data;
  logic [7:0] out_data, pend_data;
  logic       out_valid;
  logic       out_valid_next, pend_valid_next;
  logic [7:0] out_data_next, pend_data_next;

  assign res      = chain[ENTITY_SLOTS-1];
  assign push     = res.valid;
  assign res_data = {3'b000, res.hit_slot, res.found};
  assign pop      = out_valid && m_axis_tready;

  always_comb begin
    out_valid_next  = out_valid;
    out_data_next   = out_data;
    pend_valid_next = pend_valid;
    pend_data_next  = pend_data;
    if (pop) begin
      out_valid_next  = pend_valid;
      out_data_next   = pend_data;
      pend_valid_next = 1'b0;
    end
    if (push) begin
      if (!out_valid_next) begin
        out_valid_next = 1'b1;
        out_data_next  = res_data;
      end else begin
        pend_valid_next = 1'b1;
        pend_data_next  = res_data;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      out_valid       <= 1'b0;
      pend_valid      <= 1'b0;
      tok_entry.valid <= 1'b0;
      tok_entry.found <= 1'b0;
    end else begin
      out_valid       <= out_valid_next;
      pend_valid      <= pend_valid_next;
      tok_entry.valid <= accept && (in_cmd == CMD_QUERY);
      tok_entry.found <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (in_cmd)
              CMD_WRITE_SLOT: state <= ST_ENT_WR;
              CMD_QUERY:      state <= ST_QUERY;
              default:        state <= ST_IDLE;
            endcase
          end
        end
        ST_ENT_WR: begin
          state <= ST_IDLE;
        end
        ST_QUERY: begin
          // hold until the token leaves the last cell
          if (res.valid) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
    out_data  <= out_data_next;
    pend_data <= pend_data_next;
    if (accept) begin
      wr_slot            <= in_slot;
      wr_type            <= in_type;
      wr_type_ok         <= in_type_ok;
      wr_px              <= in_px;
      wr_py              <= in_py;
      wr_pz              <= in_pz;
      tok_entry.hit_slot <= '0;
      tok_entry.start    <= in_slot;
      tok_entry.ignore   <= in_ignore;
      tok_entry.q        <= query_box(in_px, in_py, in_pz, in_ex, in_ey, in_ez);
    end
  end

endmodule

// ===== hdl/ahs_ram.sv =====
module ahs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/ahs_cell.sv =====
module ahs_cell import ahs_pkg::*; #(
  parameter int INDEX = 0
) (
  input  logic   clk,
  input  logic   rst,
  input  upd_t   upd,
  input  token_t tok_in,
  output token_t tok_out
);

  localparam logic [IDX_W-1:0] IDX = IDX_W'(INDEX);

  logic              present;
  logic [TYPE_W-1:0] etype;
  pos_t              px;
  pos_t              py;
  pos_t              pz;
  box_t              box;
  logic              my_slot;
  logic              hit;

  assign my_slot = ({{(IDX_W - SLOT_W){1'b0}}, upd.slot} == IDX);

  assign hit = tok_in.valid && !tok_in.found && present &&
               ({{(IDX_W - SLOT_W){1'b0}}, tok_in.start} <= IDX) &&
               ({{(IDX_W - SLOT_W){1'b0}}, tok_in.ignore} != IDX) &&
               boxes_overlap(box, tok_in.q);

  // Slot contents; the box is rebuilt whenever position or dimensions change
  always_ff @(posedge clk) begin
    if (rst) begin
      present <= 1'b0;
    end else if (upd.ent_we && my_slot) begin
      present <= 1'b1;
    end else if (upd.clr && my_slot) begin
      present <= 1'b0;
    end
    if (upd.ent_we && my_slot) begin
      etype <= upd.etype;
      px    <= upd.px;
      py    <= upd.py;
      pz    <= upd.pz;
      box   <= entity_box(upd.px, upd.py, upd.pz, upd.rad, upd.hgt);
    end else if (upd.dims_we && (upd.etype == etype)) begin
      box   <= entity_box(px, py, pz, upd.rad, upd.hgt);
    end
  end

  // Advance the query token one cell per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
      tok_out.found <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
      tok_out.found <= tok_in.found | hit;
    end
    tok_out.hit_slot <= hit ? HIT_W'(INDEX) : tok_in.hit_slot;
    tok_out.start    <= tok_in.start;
    tok_out.ignore   <= tok_in.ignore;
    tok_out.q        <= tok_in.q;
  end

endmodule

// ===== hdl/ahs_checker.sv =====
module ahs_checker import ahs_pkg::*; #(
  parameter int ENTITY_SLOTS = 16
) (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [1:0]   s_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [7:0]   m_axis_tdata
);

  // Reset empties the result queue
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // A waiting result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");

  // No-hit results carry slot zero
  a_nohit_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[7:1] == 7'd0)
    else $error("no-hit result with nonzero slot");

  // A hit names an existing slot
  a_hit_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[0] |->
      (ENTITY_SLOTS >= 16) || ({1'b0, m_axis_tdata[4:1]} < 5'(ENTITY_SLOTS)))
    else $error("hit slot beyond table");

  // Ready drops right after a slot write or query is accepted
  a_busy_after: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready &&
      (s_axis_tuser == CMD_WRITE_SLOT || s_axis_tuser == CMD_QUERY)
      |=> !s_axis_tready)
    else $error("ready directly after a slot write or query");

endmodule

bind aabb_entity_hit_search ahs_checker #(.ENTITY_SLOTS(ENTITY_SLOTS)) u_ahs_checker (.*);

// ===== verif/aabb_hit_checker.sv =====
module aabb_hit_checker import ahs_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [151:0] s_axis_tdata,
  input  logic [1:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [7:0]   m_axis_tdata,
  output int           mismatches,
  output int           queries_in_flight,
  output int           results_checked,
  output int           hits_reported
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 16;
  localparam int TYPES = 256;

  typedef struct packed {
    logic             found;
    logic [HIT_W-1:0] slot;
  } hit_t;

  logic              present  [SLOTS];
  logic [TYPE_W-1:0] ent_type [SLOTS];
  pos_t              ent_x    [SLOTS];
  pos_t              ent_y    [SLOTS];
  pos_t              ent_z    [SLOTS];
  dim_t              type_rad [TYPES];
  dim_t              type_hgt [TYPES];
  hit_t              pending_hits[$];

  function automatic bit axis_apart(input int ac, input int ae, input int bc, input int be);
    return (bc + be < ac - ae) || (bc - be > ac + ae);
  endfunction

  // Scan upward from the start slot; first overlapping box wins
  function automatic hit_t find_first_hit(input logic [151:0] d);
    int   qx, qy, qz, ex, ey, ez, hr, hh, s, start, skip;
    pos_t ycen;
    hit_t r;
    r     = '0;
    start = int'(d[4:0]);
    skip  = int'(d[9:5]);
    qx    = int'($signed(d[33:18]));
    qy    = int'($signed(d[49:34]));
    qz    = int'($signed(d[65:50]));
    ex    = int'($signed(d[81:66]));
    ey    = int'($signed(d[97:82]));
    ez    = int'($signed(d[113:98]));
    for (s = start; s < SLOTS; s++) begin
      if (!present[s] || s == skip) continue;
      hr   = int'(type_rad[ent_type[s]][POS_W-1:1]);
      hh   = int'(type_hgt[ent_type[s]][POS_W-1:1]);
      ycen = ent_y[s] - pos_t'(hh);
      if (axis_apart(qx, ex, int'(ent_x[s]), hr) || axis_apart(qy, ey, int'(ycen), hh) ||
          axis_apart(qz, ez, int'(ent_z[s]), hr)) continue;
      r.found = 1'b1;
      r.slot  = s[HIT_W-1:0];
      return r;
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    hit_t             want;
    logic [SLOT_W-1:0] slot;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) present[i] = 1'b0;
      pending_hits.delete();
      mismatches        <= 0;
      queries_in_flight <= 0;
      results_checked   <= 0;
      hits_reported     <= 0;
    end else begin
      // results first: a query taken at this edge cannot answer at the same edge
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_hits.size() == 0) begin
          $error("result with no query waiting: hit_found %0d hit_slot %0d",
                 m_axis_tdata[0], m_axis_tdata[4:1]);
          mismatches <= mismatches + 1;
        end else begin
          want = pending_hits.pop_front();
          if (m_axis_tdata[0] !== want.found) begin
            $error("hit_found mismatch: expected %0d, got %0d", want.found, m_axis_tdata[0]);
            mismatches <= mismatches + 1;
          end else if (m_axis_tdata[4:1] !== want.slot) begin
            $error("hit_slot mismatch: expected %0d, got %0d", want.slot, m_axis_tdata[4:1]);
            mismatches <= mismatches + 1;
          end
          results_checked <= results_checked + 1;
          if (want.found) hits_reported <= hits_reported + 1;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        slot = s_axis_tdata[4:0];
        case (cmd_t'(s_axis_tuser))
          CMD_WRITE_SLOT: if (slot < SLOTS) begin
            present[slot[3:0]]  = 1'b1;
            ent_type[slot[3:0]] = s_axis_tdata[17:10];
            ent_x[slot[3:0]]    = s_axis_tdata[33:18];
            ent_y[slot[3:0]]    = s_axis_tdata[49:34];
            ent_z[slot[3:0]]    = s_axis_tdata[65:50];
          end
          CMD_CLEAR_SLOT: if (slot < SLOTS) present[slot[3:0]] = 1'b0;
          CMD_WRITE_TYPE: begin
            type_rad[s_axis_tdata[17:10]] = s_axis_tdata[129:114];
            type_hgt[s_axis_tdata[17:10]] = s_axis_tdata[145:130];
          end
          default: pending_hits.push_back(find_first_hit(s_axis_tdata));
        endcase
      end
      queries_in_flight <= pending_hits.size();
    end
  end

endmodule

// ===== verif/tb_aabb_entity_hit_search.sv =====
module tb_aabb_entity_hit_search;
  import ahs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // idle time after the final drain; give margin
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_ITEMS  = 950;

  bit         clk;
  bit         rst = 1'b1;
  bit         s_axis_tvalid;
  logic       s_axis_tready;
  bit [151:0] s_axis_tdata;
  bit [1:0]   s_axis_tuser;
  logic       m_axis_tvalid;
  bit         m_axis_tready;
  logic [7:0] m_axis_tdata;

  int mismatches, queries_in_flight, results_checked, hits_reported;
  int commands_sent;
  int burst_left;
  int stall_mode, mode_left;

  // types whose dimensions are written; entities only ever take one of these
  bit [TYPE_W-1:0] known_types[$];
  bit              type_known[256];

  aabb_entity_hit_search u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  aabb_hit_checker u_checker (
    .clk               (clk),
    .rst               (rst),
    .s_axis_tvalid     (s_axis_tvalid),
    .s_axis_tready     (s_axis_tready),
    .s_axis_tdata      (s_axis_tdata),
    .s_axis_tuser      (s_axis_tuser),
    .m_axis_tvalid     (m_axis_tvalid),
    .m_axis_tready     (m_axis_tready),
    .m_axis_tdata      (m_axis_tdata),
    .mismatches        (mismatches),
    .queries_in_flight (queries_in_flight),
    .results_checked   (results_checked),
    .hits_reported     (hits_reported)
  );

  initial forever #6 clk = ~clk;

  // Result side: switch among always ready, coin flip, long stalls and light
  // stalls, each held for a random stretch of cycles.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_mode    <= 0;
      mode_left     <= 0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(20, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= 1'($urandom_range(0, 1));
        2:       m_axis_tready <= ($urandom_range(0, 7) == 0);
        default: m_axis_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Present one transaction and hold it until accepted. Bursts of random length
  // alternate with idle gaps; now and then a long burst runs with no gap at all.
  task automatic send_command(input cmd_t cmd, input bit [4:0] slot, input bit [4:0] skip,
                              input bit [7:0] etype, input pos_t px, input pos_t py,
                              input pos_t pz, input pos_t ex, input pos_t ey, input pos_t ez,
                              input dim_t rad, input dim_t hgt);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 16);
      gap        = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 4);
    end
    burst_left--;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {6'd0, hgt, rad, ez, ey, ex, pz, py, px, etype, skip, slot};
    do @(posedge clk); while (!s_axis_tready);
    commands_sent++;
  endtask

  task automatic send_dims(input bit [7:0] etype, input dim_t rad, input dim_t hgt);
    send_command(CMD_WRITE_TYPE, 5'($urandom), 5'($urandom), etype,
                 pos_t'($urandom), pos_t'($urandom), pos_t'($urandom),
                 pos_t'($urandom), pos_t'($urandom), pos_t'($urandom), rad, hgt);
    if (!type_known[etype]) known_types.push_back(etype);
    type_known[etype] = 1'b1;
  endtask

  task automatic send_entity(input bit [4:0] slot, input bit [7:0] etype,
                             input pos_t px, input pos_t py, input pos_t pz);
    send_command(CMD_WRITE_SLOT, slot, 5'($urandom), etype, px, py, pz,
                 pos_t'($urandom), pos_t'($urandom), pos_t'($urandom),
                 dim_t'($urandom), dim_t'($urandom));
  endtask

  task automatic send_clear(input bit [4:0] slot);
    send_command(CMD_CLEAR_SLOT, slot, 5'($urandom), 8'($urandom),
                 pos_t'($urandom), pos_t'($urandom), pos_t'($urandom),
                 pos_t'($urandom), pos_t'($urandom), pos_t'($urandom),
                 dim_t'($urandom), dim_t'($urandom));
  endtask

  task automatic send_query(input bit [4:0] start, input bit [4:0] skip, input pos_t px,
                            input pos_t py, input pos_t pz, input pos_t ex, input pos_t ey,
                            input pos_t ez);
    send_command(CMD_QUERY, start, skip, 8'($urandom), px, py, pz, ex, ey, ez,
                 dim_t'($urandom), dim_t'($urandom));
  endtask

  // Drop valid and hold until every query has answered. The extra edge lets
  // the checker count a query accepted at the edge just passed.
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (queries_in_flight != 0) @(posedge clk);
  endtask

  // Coordinates cluster around a few hot spots so boxes actually meet,
  // including both ends of the 16-bit range where the y center wraps.
  function automatic pos_t pick_coord();
    int hot;
    case ($urandom_range(0, 9))
      0, 1, 2: hot = 0;
      3:       hot = 1000;
      4:       hot = -1000;
      5:       hot = 32767;
      6:       hot = -32768;
      default: return pos_t'($urandom);
    endcase
    return pos_t'(hot + int'($urandom_range(0, 400)) - 200);
  endfunction

  function automatic pos_t pick_extent();
    case ($urandom_range(0, 9))
      0:       return pos_t'($urandom);
      1:       return -pos_t'($urandom_range(0, 300));
      2, 3:    return pos_t'($urandom_range(0, 3000));
      default: return pos_t'($urandom_range(0, 300));
    endcase
  endfunction

  function automatic dim_t pick_dim();
    case ($urandom_range(0, 5))
      0:       return dim_t'($urandom);
      1, 2:    return dim_t'($urandom_range(0, 4000));
      default: return dim_t'($urandom_range(0, 400));
    endcase
  endfunction

  function automatic bit [4:0] pick_slot();
    return ($urandom_range(0, 11) == 0) ? 5'($urandom_range(16, 31)) : 5'($urandom_range(0, 15));
  endfunction

  // Mostly entity writes and queries over a populated table; the rest are
  // type writes, clears and writes to slots past the table.
  task automatic post_random_command();
    int       pick;
    bit [4:0] start, skip;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      if ($urandom_range(0, 1) == 0)
        send_dims(known_types[$urandom_range(0, known_types.size() - 1)], pick_dim(), pick_dim());
      else
        send_dims(8'($urandom_range(0, 255)), pick_dim(), pick_dim());
    end else if (pick < 35) begin
      send_entity(pick_slot(), known_types[$urandom_range(0, known_types.size() - 1)],
                  pick_coord(), pick_coord(), pick_coord());
    end else if (pick < 43) begin
      send_clear(pick_slot());
    end else begin
      case ($urandom_range(0, 9))
        0:       start = 5'($urandom_range(16, 31));
        1, 2:    start = 5'($urandom_range(1, 15));
        default: start = 5'd0;
      endcase
      case ($urandom_range(0, 19))
        0, 1, 2:            skip = 5'($urandom_range(17, 31));
        3, 4, 5, 6, 7, 8, 9: skip = 5'd16;
        default:            skip = 5'($urandom_range(0, 15));
      endcase
      send_query(start, skip, pick_coord(), pick_coord(), pick_coord(),
                 pick_extent(), pick_extent(), pick_extent());
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: dimension extremes, empty table, touching boxes, y wrap,
    // ignored slot, out-of-range start/slot/ignore, negative and full extents
    send_dims(8'd0, 16'd0, 16'd0);
    send_dims(8'd255, 16'hFFFF, 16'hFFFF);
    send_dims(8'd1, 16'd100, 16'd40);
    send_dims(8'hAA, 16'd21, 16'd20);
    send_query(5'd0, 5'd16, 16'sd0, 16'sd0, 16'sd0, 16'sd100, 16'sd100, 16'sd100);
    send_entity(5'd0, 8'd1, 16'sd0, 16'sd0, 16'sd0);
    send_entity(5'd15, 8'd255, 16'sd32767, -16'sd32768, 16'sd32767);
    send_entity(5'd31, 8'd0, 16'sd5, 16'sd5, 16'sd5);
    send_entity(5'd7, 8'd0, -16'sd32768, -16'sd32768, -16'sd32768);
    send_entity(5'd9, 8'hAA, -16'sd1000, 16'sd1000, 16'sd500);
    send_query(5'd0, 5'd16, 16'sd0, -16'sd20, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_query(5'd0, 5'd0, 16'sd0, -16'sd20, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_query(5'd1, 5'd16, 16'sd0, -16'sd20, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_query(5'd16, 5'd16, 16'sd0, 16'sd0, 16'sd0, 16'sd32767, 16'sd32767, 16'sd32767);
    send_query(5'd31, 5'd31, 16'sd0, 16'sd0, 16'sd0, 16'sd32767, 16'sd32767, 16'sd32767);
    send_query(5'd0, 5'd16, 16'sd0, 16'sd0, 16'sd0, -16'sd1, -16'sd1, -16'sd1);
    send_query(5'd0, 5'd16, -16'sd32768, -16'sd32768, -16'sd32768,
               16'sd32767, 16'sd32767, 16'sd32767);
    send_query(5'd1, 5'd15, -16'sd32768, -16'sd32768, -16'sd32768, 16'sd0, 16'sd0, 16'sd0);
    send_query(5'd0, 5'd31, 16'sd32767, 16'sd32767, 16'sd32767,
               -16'sd32768, -16'sd32768, -16'sd32768);
    send_clear(5'd0);
    send_clear(5'd20);
    send_query(5'd0, 5'd16, 16'sd0, -16'sd20, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_dims(8'd1, 16'hFFFE, 16'd1);
    send_entity(5'd3, 8'd1, 16'sd100, 16'sd32767, -16'sd100);
    send_query(5'd0, 5'd31, 16'sd100, 16'sd32767, -16'sd100, 16'sd0, 16'sd0, 16'sd0);
    wait_for_results();

    // random: pause for a full drain every few hundred commands
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      post_random_command();
      if (n % 300 == 299) wait_for_results();
    end
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d commands; checked %0d query results, %0d of them hits, %0d types in use.",
             commands_sent, results_checked, hits_reported, known_types.size());
    if (mismatches == 0 && queries_in_flight == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
